@@ src/sfp_pkg.sv @@
// ----------------------------------------------------------------------------
// sfp_pkg
// Types and constants shared by the scale request frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

   // frame characters
   localparam logic [7:0] START_CHAR = 8'h23;
   localparam logic [7:0] LF_CHAR    = 8'h0A;
   localparam logic [7:0] ACK_CHAR   = 8'h06;
   localparam logic [7:0] NAK_CHAR   = 8'h15;
   localparam logic [7:0] CS_OR      = 8'h40;
   localparam logic [7:0] DIGIT_LO   = 8'h30;
   localparam logic [7:0] DIGIT_HI   = 8'h39;

   // reply codes
   localparam logic [2:0] REPLY_NONE   = 3'd0;
   localparam logic [2:0] REPLY_ACK    = 3'd1;
   localparam logic [2:0] REPLY_NAK    = 3'd2;
   localparam logic [2:0] REPLY_WEIGHT = 3'd3;
   localparam logic [2:0] REPLY_TARE   = 3'd4;

   // parser phases
   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_DIGIT1   = 3'd1;
   localparam logic [2:0] PH_DIGIT2   = 3'd2;
   localparam logic [2:0] PH_COMMAND  = 3'd3;
   localparam logic [2:0] PH_CHECKSUM = 3'd4;
   localparam logic [2:0] PH_SENT     = 3'd5;

   // register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STATION_ADDRESS = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CODE_WEIGHT     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CODE_TARE_VALUE = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CODE_TARE       = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CODE_ZERO       = 3'd4;

   // register reset values
   localparam logic [6:0] RST_STATION_ADDRESS = 7'd1;
   localparam logic [7:0] RST_CODE_WEIGHT     = 8'd87;
   localparam logic [7:0] RST_CODE_TARE_VALUE = 8'd86;
   localparam logic [7:0] RST_CODE_TARE       = 8'd84;
   localparam logic [7:0] RST_CODE_ZERO       = 8'd90;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       error_active;
   } req_type;

   typedef struct packed {
      logic [2:0] reply;
      logic       tare_request;
      logic       zero_request;
      logic       timeout_reload;
   } rsp_type;

   typedef struct packed {
      logic [6:0] station_address;
      logic [7:0] code_weight;
      logic [7:0] code_tare_value;
      logic [7:0] code_tare;
      logic [7:0] code_zero;
   } cfg_type;

   typedef struct packed {
      logic [2:0] phase;
      logic [7:0] running_xor;
      logic [7:0] pending_command;
      logic       awaiting_ack;
      logic [7:0] saved_command;
   } state_type;

endpackage

`default_nettype wire

@@ src/scale_request_frame_parser.sv @@
// ----------------------------------------------------------------------------
// scale_request_frame_parser
// Parses multidrop scale request frames one received byte at a time.
// ----------------------------------------------------------------------------
// Feed each received byte with the current error flag on the req_ channel.
// Every byte yields exactly one transaction on the rsp_ channel: the reply
// kind, tare and zero request flags and the line timeout reload flag.
// A byte is taken into an input register, handled by one pass of parser
// logic that updates the frame state, and its result lands in an output
// register, which drives rsp_valid. One byte per cycle is sustained while
// the receiver does not stall.
// When rsp_stall is high the result holds, the input register takes one more
// byte if it is empty, and then req_stall rises until the result drains.
// The csr_ channel writes the station address and command codes at any time
// (csr_ready is always high); write them only while the parser is idle.
// A synchronous reset empties both registers, clears the frame state and
// restores station 1 and the command codes W, V, T and Z.
// ----------------------------------------------------------------------------
`default_nettype none

module scale_request_frame_parser
   import sfp_pkg::*;
(
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire  req_type              req_data,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output rsp_type                    rsp_data,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire  [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire  [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic      in_valid_ff;
   req_type   in_data_ff;
   logic      out_valid_ff;
   rsp_type   out_data_ff;
   cfg_type   cfg_ff;
   state_type state_ff;
   logic [7:0] first_digit_ff;

   state_type state_in;
   rsp_type   result_in;
   logic      first_digit_load;
   logic      advance;
   logic      take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   sfp_step u_step (
      .item             (in_data_ff),
      .cfg              (cfg_ff),
      .state            (state_ff),
      .first_digit      (first_digit_ff),
      .first_digit_load (first_digit_load),
      .state_next       (state_in),
      .result           (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         cfg_ff.station_address <= RST_STATION_ADDRESS;
         cfg_ff.code_weight     <= RST_CODE_WEIGHT;
         cfg_ff.code_tare_value <= RST_CODE_TARE_VALUE;
         cfg_ff.code_tare       <= RST_CODE_TARE;
         cfg_ff.code_zero       <= RST_CODE_ZERO;
      end else begin
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_STATION_ADDRESS: cfg_ff.station_address <= csr_wdata[6:0];
               CSR_CODE_WEIGHT:     cfg_ff.code_weight     <= csr_wdata;
               CSR_CODE_TARE_VALUE: cfg_ff.code_tare_value <= csr_wdata;
               CSR_CODE_TARE:       cfg_ff.code_tare       <= csr_wdata;
               CSR_CODE_ZERO:       cfg_ff.code_zero       <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result_in;
      end
      if (advance && first_digit_load) begin
         first_digit_ff <= in_data_ff.rx_byte;
      end
   end

endmodule

`default_nettype wire

@@ src/sfp_step.sv @@
// ----------------------------------------------------------------------------
// sfp_step
// Next parser state and result for one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_step
   import sfp_pkg::*;
(
   input  wire  req_type   item,
   input  wire  cfg_type   cfg,
   input  wire  state_type state,
   input  wire  [7:0]      first_digit,
   output logic            first_digit_load,
   output state_type       state_next,
   output rsp_type         result
);

   logic [7:0] b;
   logic       fd_is_digit;
   logic       b_is_digit;
   logic [6:0] station_value;
   logic       known_cmd;
   logic [7:0] cmd;

   assign b             = item.rx_byte;
   assign fd_is_digit   = (first_digit >= DIGIT_LO) && (first_digit <= DIGIT_HI);
   assign b_is_digit    = (b >= DIGIT_LO) && (b <= DIGIT_HI);
   assign station_value = 7'(first_digit[3:0] * 4'd10) + {3'd0, b[3:0]};
   assign known_cmd     = (b == ACK_CHAR) || (b == NAK_CHAR) || (b == cfg.code_weight) ||
                          (b == cfg.code_tare_value) || (b == cfg.code_tare) ||
                          (b == cfg.code_zero);

   always_comb begin
      state_next       = state;
      first_digit_load = 1'b0;
      result           = '0;
      cmd              = state.pending_command;
      case (state.phase)
         PH_DIGIT1: begin
            first_digit_load = 1'b1;
            state_next.phase = PH_DIGIT2;
         end
         PH_DIGIT2: begin
            if (fd_is_digit && b_is_digit && (station_value == cfg.station_address)) begin
               state_next.phase = PH_COMMAND;
            end else begin
               state_next.phase = PH_IDLE;
            end
         end
         PH_COMMAND: begin
            if (b == LF_CHAR) begin
               state_next.phase = PH_IDLE;
               result.reply     = REPLY_ACK;
            end else if (known_cmd) begin
               state_next.phase           = PH_CHECKSUM;
               state_next.pending_command = b;
            end else begin
               state_next.phase = PH_IDLE;
               result.reply     = REPLY_NAK;
            end
         end
         PH_CHECKSUM: begin
            state_next.phase = PH_IDLE;
            if ((state.running_xor | CS_OR) != b) begin
               result.reply = REPLY_NAK;
            end else begin
               if (item.error_active) begin
                  cmd = cfg.code_weight;
               end
               if (cmd == ACK_CHAR) begin
                  state_next.awaiting_ack = 1'b0;
               end
               if ((cmd == NAK_CHAR) && state_next.awaiting_ack) begin
                  cmd = state.saved_command;
               end
               if (cmd == cfg.code_weight) begin
                  state_next.phase = PH_SENT;
                  result.reply     = REPLY_WEIGHT;
               end
               if (cmd == cfg.code_tare_value) begin
                  state_next.phase = PH_SENT;
                  if (result.reply == REPLY_NONE) begin
                     result.reply = REPLY_TARE;
                  end
               end
               result.tare_request = (cmd == cfg.code_tare);
               result.zero_request = (cmd == cfg.code_zero);
               if (state_next.phase == PH_SENT) begin
                  state_next.awaiting_ack  = 1'b1;
                  state_next.saved_command = cmd;
               end
               state_next.pending_command = cmd;
            end
         end
         default: begin
            if (b == START_CHAR) begin
               state_next.phase       = PH_DIGIT1;
               state_next.running_xor = '0;
            end else if (state.phase > PH_SENT) begin
               state_next.phase = PH_IDLE;
            end
         end
      endcase
      if ((state_next.phase != PH_IDLE) && (state_next.phase <= PH_SENT)) begin
         state_next.running_xor = state_next.running_xor ^ b;
      end
      result.timeout_reload = (state_next.phase != PH_IDLE);
   end

endmodule

`default_nettype wire

@@ tb/sv/scale_request_frame_parser_tb.sv @@
// ----------------------------------------------------------------------------
// scale_request_frame_parser_tb
// Self-checking bench for the scale request frame parser.
// ----------------------------------------------------------------------------
// Streams request frames into the parser: a short directed set, then mostly
// well-formed frames with random station digits, commands, checksums and
// error flags, mixed with line noise and cut-off frames. Station address and
// command codes are reloaded between runs, extremes and colliding codes
// among them. A scoreboard class tracks the frame state, predicts the reply
// for every accepted byte and compares each rsp_ transaction field by field.
// Sender gaps and receiver stalls vary by run, with one long receiver
// hold-off that backs the parser up.
// ----------------------------------------------------------------------------

import sfp_pkg::*;

class frame_reply_book;
   logic [6:0] station;
   logic [7:0] code_weight;
   logic [7:0] code_tare_value;
   logic [7:0] code_tare;
   logic [7:0] code_zero;
   logic [2:0] phase;
   logic [7:0] running_xor;
   logic [7:0] first_digit;
   logic [7:0] pending_command;
   logic [7:0] saved_command;
   logic       awaiting_ack;
   rsp_type    replies_due[$];
   int         errors;

   function new();
      station         = RST_STATION_ADDRESS;
      code_weight     = RST_CODE_WEIGHT;
      code_tare_value = RST_CODE_TARE_VALUE;
      code_tare       = RST_CODE_TARE;
      code_zero       = RST_CODE_ZERO;
      phase           = PH_IDLE;
      running_xor     = 8'h00;
      first_digit     = 8'h00;
      pending_command = 8'h00;
      saved_command   = 8'h00;
      awaiting_ack    = 1'b0;
      errors          = 0;
   endfunction

   function void set_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [7:0] v);
      case (idx)
         CSR_STATION_ADDRESS: station = v[6:0];
         CSR_CODE_WEIGHT:     code_weight = v;
         CSR_CODE_TARE_VALUE: code_tare_value = v;
         CSR_CODE_TARE:       code_tare = v;
         CSR_CODE_ZERO:       code_zero = v;
         default: ;
      endcase
   endfunction

   function void take_byte(req_type t);
      logic [7:0] b;
      logic [7:0] cmd;
      rsp_type    r;
      b = t.rx_byte;
      r = '0;
      r.reply = REPLY_NONE;
      case (phase)
         PH_DIGIT1: begin
            first_digit = b;
            phase = PH_DIGIT2;
         end
         PH_DIGIT2: begin
            if (first_digit >= DIGIT_LO && first_digit <= DIGIT_HI &&
                b >= DIGIT_LO && b <= DIGIT_HI &&
                int'(first_digit - DIGIT_LO) * 10 + int'(b - DIGIT_LO) == int'(station))
               phase = PH_COMMAND;
            else
               phase = PH_IDLE;
         end
         PH_COMMAND: begin
            if (b == LF_CHAR) begin
               phase = PH_IDLE;
               r.reply = REPLY_ACK;
            end else if (b == ACK_CHAR || b == NAK_CHAR || b == code_weight ||
                         b == code_tare_value || b == code_tare || b == code_zero) begin
               phase = PH_CHECKSUM;
               pending_command = b;
            end else begin
               phase = PH_IDLE;
               r.reply = REPLY_NAK;
            end
         end
         PH_CHECKSUM: begin
            phase = PH_IDLE;
            if ((running_xor | CS_OR) != b) begin
               r.reply = REPLY_NAK;
            end else begin
               cmd = pending_command;
               if (t.error_active) cmd = code_weight;
               if (cmd == ACK_CHAR) awaiting_ack = 1'b0;
               if (cmd == NAK_CHAR && awaiting_ack) cmd = saved_command;
               if (cmd == code_weight) begin
                  phase = PH_SENT;
                  r.reply = REPLY_WEIGHT;
               end
               if (cmd == code_tare_value) begin
                  phase = PH_SENT;
                  if (r.reply == REPLY_NONE) r.reply = REPLY_TARE;
               end
               r.tare_request = (cmd == code_tare);
               r.zero_request = (cmd == code_zero);
               if (phase == PH_SENT) begin
                  awaiting_ack = 1'b1;
                  saved_command = cmd;
               end
               pending_command = cmd;
            end
         end
         default: begin
            if (b == START_CHAR) begin
               phase = PH_DIGIT1;
               running_xor = 8'h00;
            end else if (phase > PH_SENT) begin
               phase = PH_IDLE;
            end
         end
      endcase
      if (phase != PH_IDLE && phase <= PH_SENT) running_xor = running_xor ^ b;
      r.timeout_reload = (phase != PH_IDLE);
      replies_due.push_back(r);
   endfunction

   function void check_reply(rsp_type got);
      rsp_type want;
      if (replies_due.size() == 0) begin
         $error("unexpected transaction: reply %0d", got.reply);
         errors++;
         return;
      end
      want = replies_due.pop_front();
      if (got.reply !== want.reply) begin
         $error("reply: expected %0d, actual %0d", want.reply, got.reply);
         errors++;
      end
      if (got.tare_request !== want.tare_request) begin
         $error("tare_request: expected %0d, actual %0d", want.tare_request, got.tare_request);
         errors++;
      end
      if (got.zero_request !== want.zero_request) begin
         $error("zero_request: expected %0d, actual %0d", want.zero_request, got.zero_request);
         errors++;
      end
      if (got.timeout_reload !== want.timeout_reload) begin
         $error("timeout_reload: expected %0d, actual %0d",
                want.timeout_reload, got.timeout_reload);
         errors++;
      end
   endfunction

   function int pending();
      return replies_due.size();
   endfunction
endclass

module scale_request_frame_parser_tb;

   logic                       clock;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_type                    req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   frame_reply_book book = new();

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   int   bytes_sent     = 0;
   int   hold_left      = 0;
   logic hold_req       = 1'b0;
   logic hold_seen      = 1'b0;

   scale_request_frame_parser u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= 300;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) book.check_reply(rsp_data);
   end

   function automatic logic rand_err();
      return ($urandom_range(99) < 10);
   endfunction

   task automatic send_byte(logic [7:0] b, logic e);
      req_type item;
      int      gap;
      item.rx_byte = b;
      item.error_active = e;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.take_byte(item);
      bytes_sent++;
   endtask

   task automatic send_frame(logic [7:0] d1, logic [7:0] d2, logic [7:0] cmd,
                             logic good, logic cs_err, int length);
      logic [7:0] frame [5];
      int         i;
      frame[0] = START_CHAR;
      frame[1] = d1;
      frame[2] = d2;
      frame[3] = cmd;
      frame[4] = (START_CHAR ^ d1 ^ d2 ^ cmd) | CS_OR;
      if (!good) frame[4] = frame[4] ^ 8'($urandom_range(1, 255));
      if (cmd == LF_CHAR && length > 4) length = 4;
      for (i = 0; i < length; i++) send_byte(frame[i], (i == 4) ? cs_err : rand_err());
   endtask

   task automatic random_frame();
      logic [7:0] d1;
      logic [7:0] d2;
      logic [7:0] cmd;
      int         pick;
      int         length;
      if ($urandom_range(99) < 10)
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom), rand_err());
      pick = $urandom_range(99);
      if (pick < 80 && book.station <= 7'd99) begin
         d1 = DIGIT_LO + 8'(int'(book.station) / 10);
         d2 = DIGIT_LO + 8'(int'(book.station) % 10);
      end else if (pick < 92) begin
         d1 = DIGIT_LO + 8'($urandom_range(9));
         d2 = DIGIT_LO + 8'($urandom_range(9));
      end else begin
         d1 = 8'($urandom);
         d2 = 8'($urandom);
      end
      case ($urandom_range(9))
         0: cmd = LF_CHAR;
         1: cmd = ACK_CHAR;
         2, 3: cmd = NAK_CHAR;
         4: cmd = book.code_weight;
         5: cmd = book.code_tare_value;
         6: cmd = book.code_tare;
         7: cmd = book.code_zero;
         8: cmd = 8'($urandom);
         default: cmd = 8'($urandom_range(8'h20, 8'h7E));
      endcase
      length = ($urandom_range(99) < 4) ? $urandom_range(1, 3) : 5;
      send_frame(d1, d2, cmd, $urandom_range(99) >= 12, $urandom_range(99) < 15, length);
   endtask

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [7:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      book.set_reg(idx, v);
   endtask

   task automatic load_settings(cfg_type c);
      write_reg(CSR_STATION_ADDRESS, {1'($urandom_range(1)), c.station_address});
      write_reg(CSR_CODE_WEIGHT, c.code_weight);
      write_reg(CSR_CODE_TARE_VALUE, c.code_tare_value);
      write_reg(CSR_CODE_TARE, c.code_tare);
      write_reg(CSR_CODE_ZERO, c.code_zero);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_replies();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (book.pending() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task automatic set_idle(int s_pct, int r_pct);
      send_idle_pct = s_pct;
      recv_stall_pct <= r_pct;
   endtask

   initial begin
      cfg_type c;
      int      s;
      int      run_end;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      set_idle(29, 74);

      send_byte(8'hFF, 1'b1);
      send_frame("0", "1", LF_CHAR, 1'b1, 1'b0, 5);
      send_frame("0", "1", RST_CODE_WEIGHT, 1'b1, 1'b0, 5);
      send_frame("0", "1", NAK_CHAR, 1'b1, 1'b0, 5);
      send_frame("0", "1", RST_CODE_TARE, 1'b1, 1'b1, 5);
      send_frame("0", "1", RST_CODE_TARE_VALUE, 1'b0, 1'b0, 5);

      for (s = 0; s < 6; s++) begin
         wait_replies();
         repeat (4) @(posedge clock);
         case (s)
            1: load_settings('{7'd99, 8'h00, 8'hFF, ACK_CHAR, LF_CHAR});
            2: load_settings('{7'd0, 8'h41, 8'h41, 8'h41, 8'h41});
            3: load_settings('{7'(100 + $urandom_range(27)), 8'($urandom), 8'($urandom),
                               8'($urandom), 8'($urandom)});
            4: load_settings('{7'($urandom_range(99)), 8'($urandom), 8'($urandom),
                               8'($urandom), 8'($urandom)});
            5: load_settings('{7'd42, NAK_CHAR, START_CHAR, 8'hFF, 8'h00});
            default: ;
         endcase
         if (s == 2) set_idle(74, 29);
         if (s == 4) begin
            set_idle(0, 0);
            hold_req <= ~hold_req;
         end
         run_end = bytes_sent + 255;
         while (bytes_sent < run_end) random_frame();
      end
      req_valid <= 1'b0;

      wait_replies();
      repeat (8) @(posedge clock);
      if (book.pending() != 0) begin
         $error("%0d expected transactions never arrived", book.pending());
         book.errors++;
      end
      if (book.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
src/sfp_pkg.sv
src/sfp_step.sv
src/scale_request_frame_parser.sv
tb/sv/scale_request_frame_parser_tb.sv
